// ===== rtl/cvalu_pkg.sv =====
// Shared types, constants and helpers for the complex vector ALU.
`timescale 1ns / 1ps
package cvalu_pkg;

    // Fixed field width of every data value, and derived widths
    localparam int DATA_W    = 32;
    localparam int PW        = 2 * DATA_W;      // product / divisor width
    localparam int SW        = 2 * DATA_W + 1;  // exact sum of two products
    localparam int AW        = DATA_W + 1;      // sum of two data values
    localparam int QW        = DATA_W + 2;      // quotient bits, two above DATA_W for overflow
    localparam int CFG_IDX_W = 2;
    localparam int LATENCY   = QW + 4;          // accept edge to result edge

    // Request codes
    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_ADD_RE = 4'd1;
    localparam logic [3:0] OP_ADD_IM = 4'd2;
    localparam logic [3:0] OP_SUB    = 4'd3;
    localparam logic [3:0] OP_MUL    = 4'd4;
    localparam logic [3:0] OP_SCALE  = 4'd5;
    localparam logic [3:0] OP_DIV    = 4'd6;
    localparam logic [3:0] OP_DIV_RE = 4'd7;
    localparam logic [3:0] OP_MAGSQ  = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALAR_RE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALAR_IM = 2'd1;

    // Saturation bounds
    localparam logic signed [DATA_W-1:0] POS_W = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] NEG_W = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SW-1:0] S_POS = {{(DATA_W+2){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SW-1:0] S_NEG = {{(DATA_W+2){1'b1}}, {(DATA_W-1){1'b0}}};
    localparam logic [QW-1:0] Q_POS = {3'b000, {(DATA_W-1){1'b1}}};
    localparam logic [QW-1:0] Q_NEG = {3'b001, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]               req_type;
        logic signed [DATA_W-1:0] a_re;
        logic signed [DATA_W-1:0] a_im;
        logic signed [DATA_W-1:0] b_re;
        logic signed [DATA_W-1:0] b_im;
        logic                     use_scalar;
        logic                     is_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] res_re;
        logic signed [DATA_W-1:0] res_im;
        logic                     div_by_zero;
        logic                     saturated;
        logic                     last_out;
    } t_out_beat;

    // Data that rides along the divider chain with each element
    typedef struct packed {
        logic                     valid;
        logic                     last;
        logic                     is_div;
        logic                     dz;
        logic                     neg_re;
        logic                     neg_im;
        logic signed [DATA_W-1:0] byp_re;
        logic signed [DATA_W-1:0] byp_im;
        logic                     byp_sat;
    } t_side;

    typedef struct packed {
        t_side           side;
        logic [PW-1:0]   mag_re;
        logic [PW-1:0]   mag_im;
        logic [PW-1:0]   dvsr;
    } t_lane;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     sat;
    } t_sat;

    // Clip an exact signed value to the data range
    function automatic t_sat sat_wide(input logic signed [SW-1:0] v);
        t_sat r;
        r.sat = 1'b0;
        r.val = v[DATA_W-1:0];
        if (v > S_POS) begin
            r.val = POS_W;
            r.sat = 1'b1;
        end else if (v < S_NEG) begin
            r.val = NEG_W;
            r.sat = 1'b1;
        end
        return r;
    endfunction

    // Apply sign to a quotient magnitude and clip
    function automatic t_sat sat_quo(input logic [QW-1:0] q, input logic neg);
        t_sat r;
        r.sat = 1'b0;
        r.val = neg ? -$signed(q[DATA_W-1:0]) : $signed(q[DATA_W-1:0]);
        if (!neg && q > Q_POS) begin
            r.val = POS_W;
            r.sat = 1'b1;
        end else if (neg && q > Q_NEG) begin
            r.val = NEG_W;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

// ===== rtl/complex_vector_alu.sv =====
// Top level of the complex vector ALU: front end, divider chain, result register.
//
//  channel  | direction | handshake                   | beat
//  ---------+-----------+-----------------------------+------------------------
//  command  | in        | i_start, o_busy             | i_in  (t_in_beat)
//  result   | out       | o_done strobe, no stall     | o_out (t_out_beat)
//  config   | in        | i_cfg_valid, o_cfg_ready    | i_cfg_index, i_cfg_data
//
// One element is taken every cycle; o_busy stays low.
// Each result follows its command beat through three front stages (operands,
// products, sums), one divider cell per quotient bit (DATA_W + 2 cells), and
// the result register.
// Synchronous reset empties the pipeline; scalar registers reset to zero.
// Results are shown for one cycle only; the receiver cannot stall.
`timescale 1ns / 1ps
module complex_vector_alu #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    output logic                                  o_busy,
    input  cvalu_pkg::t_in_beat                   i_in,
    output logic                                  o_done,
    output cvalu_pkg::t_out_beat                  o_out,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [cvalu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cvalu_pkg::DATA_W-1:0]          i_cfg_data
);
    import cvalu_pkg::*;

    localparam int RW = 3 * DATA_W + FRAC_BITS + 2;

    logic                     w_accept;
    logic signed [DATA_W-1:0] r_scalar_re, r_scalar_im;
    t_lane                    w_lane;

    t_side                    w_side [0:QW];
    logic [RW-1:0]            w_rem_re [0:QW];
    logic [RW-1:0]            w_rem_im [0:QW];
    logic [QW-1:0]            w_q_re [0:QW];
    logic [QW-1:0]            w_q_im [0:QW];
    logic [PW-1:0]            w_dvsr [0:QW];

    t_side                    w_fin;
    t_sat                     w_qs_re, w_qs_im;
    t_out_beat                r_out, n_out;
    logic                     r_done;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_start && !o_busy;

    // Scalar broadcast registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scalar_re <= '0;
            r_scalar_im <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_SCALAR_RE: r_scalar_re <= i_cfg_data;
                CFG_SCALAR_IM: r_scalar_im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cvalu_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_in        (i_in),
        .i_scalar_re (r_scalar_re),
        .i_scalar_im (r_scalar_im),
        .o_lane      (w_lane)
    );

    // Seed the chain with the scaled numerators
    assign w_side[0]   = w_lane.side;
    assign w_rem_re[0] = RW'(w_lane.mag_re) << FRAC_BITS;
    assign w_rem_im[0] = RW'(w_lane.mag_im) << FRAC_BITS;
    assign w_q_re[0]   = '0;
    assign w_q_im[0]   = '0;
    assign w_dvsr[0]   = w_lane.dvsr;

    // Quotient bits from the top down, one cell each
    for (genvar j = 0; j < QW; j++) begin : g_cell
        cvalu_div_cell #(
            .K  (QW - 1 - j),
            .RW (RW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_side   (w_side[j]),
            .i_rem_re (w_rem_re[j]),
            .i_rem_im (w_rem_im[j]),
            .i_q_re   (w_q_re[j]),
            .i_q_im   (w_q_im[j]),
            .i_dvsr   (w_dvsr[j]),
            .o_side   (w_side[j+1]),
            .o_rem_re (w_rem_re[j+1]),
            .o_rem_im (w_rem_im[j+1]),
            .o_q_re   (w_q_re[j+1]),
            .o_q_im   (w_q_im[j+1]),
            .o_dvsr   (w_dvsr[j+1])
        );
    end

    // Pick quotient or bypass result and apply the flags
    assign w_fin   = w_side[QW];
    assign w_qs_re = sat_quo(w_q_re[QW], w_fin.neg_re);
    assign w_qs_im = sat_quo(w_q_im[QW], w_fin.neg_im);

    always_comb begin
        n_out.last_out    = w_fin.last;
        n_out.div_by_zero = 1'b0;
        n_out.res_re      = w_fin.byp_re;
        n_out.res_im      = w_fin.byp_im;
        n_out.saturated   = w_fin.byp_sat;
        if (w_fin.is_div) begin
            if (w_fin.dz) begin
                n_out.res_re      = POS_W;
                n_out.res_im      = POS_W;
                n_out.div_by_zero = 1'b1;
                n_out.saturated   = 1'b1;
            end else begin
                n_out.res_re    = w_qs_re.val;
                n_out.res_im    = w_qs_im.val;
                n_out.saturated = w_qs_re.sat | w_qs_im.sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_fin.valid;
        end
        r_out <= n_out;
    end

    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

// ===== rtl/cvalu_front.sv =====
// Operand select, products and exact sums ahead of the divider chain.
`timescale 1ns / 1ps
module cvalu_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  cvalu_pkg::t_in_beat              i_in,
    input  logic signed [cvalu_pkg::DATA_W-1:0] i_scalar_re,
    input  logic signed [cvalu_pkg::DATA_W-1:0] i_scalar_im,
    output cvalu_pkg::t_lane                 o_lane
);
    import cvalu_pkg::*;

    // stage 1 registers
    logic                     r_s1_v;
    logic [3:0]               r_s1_op;
    logic signed [DATA_W-1:0] r_s1_ar, r_s1_ai, r_s1_br, r_s1_bi;
    logic                     r_s1_last;

    // stage 2 registers
    logic                     r_s2_v;
    logic [3:0]               r_s2_op;
    logic signed [DATA_W-1:0] r_s2_ar, r_s2_ai, r_s2_br;
    logic                     r_s2_last;
    logic signed [AW-1:0]     r_s2_sre, r_s2_sim, n_s2_sre, n_s2_sim;
    logic signed [PW-1:0]     r_s2_m0, r_s2_m1, r_s2_m2, r_s2_m3, r_s2_m4, r_s2_m5;
    logic signed [DATA_W-1:0] w_m0_b, w_m1_b;

    // stage 3
    t_lane                    r_lane, n_lane;
    logic signed [SW-1:0]     w_s_re, w_s_im, w_n_re, w_n_im, w_abs_br;
    logic [PW-1:0]            w_dv;
    logic                     w_shift, w_is_div;
    t_sat                     w_sat_re, w_sat_im;

    // Capture the element, swap in the broadcast operand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= i_accept;
        end
        r_s1_op   <= i_in.req_type;
        r_s1_ar   <= i_in.a_re;
        r_s1_ai   <= i_in.a_im;
        r_s1_br   <= i_in.use_scalar ? i_scalar_re : i_in.b_re;
        r_s1_bi   <= i_in.use_scalar ? i_scalar_im : i_in.b_im;
        r_s1_last <= i_in.is_last;
    end

    // Plain sums for the additive requests
    always_comb begin
        n_s2_sre = AW'(r_s1_ar);
        n_s2_sim = AW'(r_s1_ai);
        case (r_s1_op)
            OP_ADD: begin
                n_s2_sre = AW'(r_s1_ar) + AW'(r_s1_br);
                n_s2_sim = AW'(r_s1_ai) + AW'(r_s1_bi);
            end
            OP_ADD_RE: n_s2_sre = AW'(r_s1_ar) + AW'(r_s1_br);
            OP_ADD_IM: n_s2_sim = AW'(r_s1_ai) + AW'(r_s1_br);
            OP_SUB: begin
                n_s2_sre = AW'(r_s1_ar) - AW'(r_s1_br);
                n_s2_sim = AW'(r_s1_ai) - AW'(r_s1_bi);
            end
            default: ;
        endcase
    end

    assign w_m0_b = (r_s1_op == OP_MAGSQ) ? r_s1_ar : r_s1_br;
    assign w_m1_b = (r_s1_op == OP_MAGSQ) ? r_s1_ai : r_s1_bi;

    // Form all partial products in parallel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_op   <= r_s1_op;
        r_s2_ar   <= r_s1_ar;
        r_s2_ai   <= r_s1_ai;
        r_s2_br   <= r_s1_br;
        r_s2_last <= r_s1_last;
        r_s2_sre  <= n_s2_sre;
        r_s2_sim  <= n_s2_sim;
        r_s2_m0   <= PW'(r_s1_ar) * PW'(w_m0_b);
        r_s2_m1   <= PW'(r_s1_ai) * PW'(w_m1_b);
        r_s2_m2   <= PW'(r_s1_ar) * PW'(r_s1_bi);
        r_s2_m3   <= PW'(r_s1_ai) * PW'(r_s1_br);
        r_s2_m4   <= PW'(r_s1_br) * PW'(r_s1_br);
        r_s2_m5   <= PW'(r_s1_bi) * PW'(r_s1_bi);
    end

    assign w_abs_br = r_s2_br[DATA_W-1] ? -SW'(r_s2_br) : SW'(r_s2_br);

    // Combine products: truncated results, or numerators and divisor; sums pass through
    always_comb begin
        w_s_re  = SW'(r_s2_sre);
        w_s_im  = SW'(r_s2_sim);
        w_n_re  = '0;
        w_n_im  = '0;
        w_dv    = '0;
        w_shift = 1'b0;
        case (r_s2_op)
            OP_MUL: begin
                w_s_re  = SW'(r_s2_m0) - SW'(r_s2_m1);
                w_s_im  = SW'(r_s2_m2) + SW'(r_s2_m3);
                w_shift = 1'b1;
            end
            OP_SCALE: begin
                w_s_re  = SW'(r_s2_m0);
                w_s_im  = SW'(r_s2_m3);
                w_shift = 1'b1;
            end
            OP_MAGSQ: begin
                w_s_re  = SW'(r_s2_m0) + SW'(r_s2_m1);
                w_s_im  = '0;
                w_shift = 1'b1;
            end
            OP_DIV: begin
                w_n_re = SW'(r_s2_m0) + SW'(r_s2_m1);
                w_n_im = SW'(r_s2_m3) - SW'(r_s2_m2);
                w_dv   = PW'(r_s2_m4) + PW'(r_s2_m5);
            end
            OP_DIV_RE: begin
                w_n_re = r_s2_br[DATA_W-1] ? -SW'(r_s2_ar) : SW'(r_s2_ar);
                w_n_im = r_s2_br[DATA_W-1] ? -SW'(r_s2_ai) : SW'(r_s2_ai);
                w_dv   = PW'(w_abs_br);
            end
            default: ;
        endcase
        if (w_shift) begin
            w_s_re = w_s_re >>> FRAC_BITS;
            w_s_im = w_s_im >>> FRAC_BITS;
        end
    end

    assign w_is_div = (r_s2_op == OP_DIV) || (r_s2_op == OP_DIV_RE);
    assign w_sat_re = sat_wide(w_s_re);
    assign w_sat_im = sat_wide(w_s_im);

    always_comb begin
        n_lane.side.valid   = r_s2_v;
        n_lane.side.last    = r_s2_last;
        n_lane.side.is_div  = w_is_div;
        n_lane.side.dz      = w_is_div && (w_dv == '0);
        n_lane.side.neg_re  = w_n_re[SW-1];
        n_lane.side.neg_im  = w_n_im[SW-1];
        n_lane.side.byp_re  = w_sat_re.val;
        n_lane.side.byp_im  = w_sat_im.val;
        n_lane.side.byp_sat = w_sat_re.sat | w_sat_im.sat;
        n_lane.mag_re       = w_n_re[SW-1] ? PW'(-w_n_re) : PW'(w_n_re);
        n_lane.mag_im       = w_n_im[SW-1] ? PW'(-w_n_im) : PW'(w_n_im);
        n_lane.dvsr         = w_dv;
    end

    // Hand off to the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane <= '0;
        end else begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

// ===== rtl/cvalu_div_cell.sv =====
// One restoring-division cell: decides one quotient bit for both parts.
`timescale 1ns / 1ps
module cvalu_div_cell #(
    parameter int K  = 0,
    parameter int RW = 114
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cvalu_pkg::t_side              i_side,
    input  logic [RW-1:0]                 i_rem_re,
    input  logic [RW-1:0]                 i_rem_im,
    input  logic [cvalu_pkg::QW-1:0]      i_q_re,
    input  logic [cvalu_pkg::QW-1:0]      i_q_im,
    input  logic [cvalu_pkg::PW-1:0]      i_dvsr,
    output cvalu_pkg::t_side              o_side,
    output logic [RW-1:0]                 o_rem_re,
    output logic [RW-1:0]                 o_rem_im,
    output logic [cvalu_pkg::QW-1:0]      o_q_re,
    output logic [cvalu_pkg::QW-1:0]      o_q_im,
    output logic [cvalu_pkg::PW-1:0]      o_dvsr
);
    import cvalu_pkg::*;

    logic [RW-1:0] w_dk;
    logic          w_ge_re, w_ge_im;
    t_side         r_side;
    logic [RW-1:0] r_rem_re, r_rem_im, n_rem_re, n_rem_im;
    logic [QW-1:0] r_q_re, r_q_im, n_q_re, n_q_im;
    logic [PW-1:0] r_dvsr;

    // Trial subtract of the divisor at this bit weight
    assign w_dk    = RW'(i_dvsr) << K;
    assign w_ge_re = i_rem_re >= w_dk;
    assign w_ge_im = i_rem_im >= w_dk;

    always_comb begin
        n_rem_re  = w_ge_re ? i_rem_re - w_dk : i_rem_re;
        n_rem_im  = w_ge_im ? i_rem_im - w_dk : i_rem_im;
        n_q_re    = i_q_re;
        n_q_im    = i_q_im;
        n_q_re[K] = w_ge_re;
        n_q_im[K] = w_ge_im;
    end

    // Pass everything to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
        r_rem_re <= n_rem_re;
        r_rem_im <= n_rem_im;
        r_q_re   <= n_q_re;
        r_q_im   <= n_q_im;
        r_dvsr   <= i_dvsr;
    end

    assign o_side   = r_side;
    assign o_rem_re = r_rem_re;
    assign o_rem_im = r_rem_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_dvsr   = r_dvsr;

endmodule

// ===== rtl/cvalu_chk.sv =====
// Port-level checks for the complex vector ALU, bound to the top level.
`timescale 1ns / 1ps
module cvalu_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   o_busy,
    input cvalu_pkg::t_in_beat    i_in,
    input logic                   o_done,
    input cvalu_pkg::t_out_beat   o_out
);
    import cvalu_pkg::*;

    // Reset empties the pipeline
    a_no_done_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    // A result comes from a command beat a fixed time earlier, with its end mark
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(i_start && !o_busy, LATENCY)
                    && o_out.last_out == $past(i_in.is_last, LATENCY)))
        else $error("result without matching command beat");

    // Zero divisor always clips
    a_dz_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.div_by_zero |-> o_out.saturated)
        else $error("divide by zero without saturation flag");

    // Zero divisor drives both parts to the positive bound
    a_dz_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_out.div_by_zero |-> (o_out.res_re == POS_W && o_out.res_im == POS_W))
        else $error("divide by zero with wrong result value");

endmodule

bind complex_vector_alu cvalu_chk u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_in    (i_in),
    .o_done  (o_done),
    .o_out   (o_out)
);
